// File: rtl/core/tlbft_pkg.sv
`timescale 1ns / 1ps
package tlbft_pkg;

  localparam int SEL_W    = 4;
  localparam int OFFSET_W = 7;
  localparam int FRAME_W  = 5;
  localparam int ADDR_W   = 11;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_MISS       = 3'd1,
    ST_FAULT      = 3'd2,
    ST_BAD_TABLE  = 3'd3,
    ST_BAD_PAGE   = 3'd4,
    ST_BAD_OFFSET = 3'd5,
    ST_WRITTEN    = 3'd6
  } status_t;

  // Class of a transaction as decided by the front end
  typedef enum logic [2:0] {
    CMD_TRANSLATE,
    CMD_WRITE,
    CMD_BAD_TABLE,
    CMD_BAD_PAGE,
    CMD_BAD_OFFSET
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [OFFSET_W-1:0]   offset;
    logic [FRAME_W-1:0]    frame;
    logic                  valid;
  } cmd_t;

  typedef struct packed {
    status_t               status;
    logic [ADDR_W-1:0]     phys_addr;
  } res_t;

  typedef enum logic {
    BK_IDLE,
    BK_LOOK
  } back_state_t;

  // Map a non-translate command straight to its status
  function automatic status_t direct_status(cmd_kind_t kind);
    status_t st;
    case (kind)
      CMD_BAD_TABLE:  st = ST_BAD_TABLE;
      CMD_BAD_PAGE:   st = ST_BAD_PAGE;
      CMD_BAD_OFFSET: st = ST_BAD_OFFSET;
      default:        st = ST_WRITTEN;
    endcase
    return st;
  endfunction

endpackage

// File: rtl/core/tlbft_front.sv
`timescale 1ns / 1ps
module tlbft_front #(
  parameter int NUM_TABLES      = 4,
  parameter int PAGES_PER_TABLE = 8,
  parameter int PAGE_SIZE       = 64,
  parameter int TAG_W           = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic                           op,
  input  logic [tlbft_pkg::SEL_W-1:0]    table_sel,
  input  logic [tlbft_pkg::SEL_W-1:0]    page_sel,
  input  logic [tlbft_pkg::OFFSET_W-1:0] offset,
  input  logic [tlbft_pkg::FRAME_W-1:0]  entry_frame,
  input  logic                           entry_valid,
  output logic                           cmd_valid,
  output tlbft_pkg::cmd_t                cmd,
  output logic [TAG_W-1:0]               cmd_tag,
  input  logic                           cmd_pop
);
  import tlbft_pkg::*;

  cmd_t                cls_cmd;
  logic [ADDR_W-1:0]   tag_full;
  cmd_t                q_cmd_r [2];
  logic [TAG_W-1:0]    q_tag_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          cnt_r;
  logic [1:0]          cnt_nxt;
  logic                do_push;
  logic                do_pop;

  // Classify: bad table, then bad page, then write, then bad offset
  always_comb begin
    tag_full       = ADDR_W'(table_sel) * ADDR_W'(PAGES_PER_TABLE) + ADDR_W'(page_sel);
    cls_cmd.offset = offset;
    cls_cmd.frame  = entry_frame;
    cls_cmd.valid  = entry_valid;
    if ({1'b0, table_sel} >= 5'(NUM_TABLES)) begin
      cls_cmd.kind = CMD_BAD_TABLE;
    end else if ({3'b000, page_sel} >= 7'(PAGES_PER_TABLE)) begin
      cls_cmd.kind = CMD_BAD_PAGE;
    end else if (op) begin
      cls_cmd.kind = CMD_WRITE;
    end else if ({4'b0000, offset} >= ADDR_W'(PAGE_SIZE)) begin
      cls_cmd.kind = CMD_BAD_OFFSET;
    end else begin
      cls_cmd.kind = CMD_TRANSLATE;
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;
  assign cmd       = q_cmd_r[rd_ptr_r];
  assign cmd_tag   = q_tag_r[rd_ptr_r];
  assign cnt_nxt   = cnt_r + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_cmd_r[wr_ptr_r] <= cls_cmd;
      q_tag_r[wr_ptr_r] <= tag_full[TAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/tlbft_back.sv
`timescale 1ns / 1ps
module tlbft_back #(
  parameter int TLB_ENTRIES = 10,
  parameter int PAGE_SIZE   = 64,
  parameter int PT_DEPTH    = 32,
  parameter int TAG_W       = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  tlbft_pkg::cmd_t  cmd,
  input  logic [TAG_W-1:0] cmd_tag,
  output logic             cmd_pop,
  input  logic             res_space,
  output logic             res_push,
  output tlbft_pkg::res_t  res
);
  import tlbft_pkg::*;

  localparam int PTR_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  back_state_t          state_r;
  back_state_t          state_nxt;

  // Page table: frames in a memory, valid bits in flops cleared by reset
  logic [FRAME_W-1:0]   pt_frame_mem [PT_DEPTH];
  logic [PT_DEPTH-1:0]  pt_valid_r;
  logic [FRAME_W-1:0]   pt_frame_r;
  logic                 pt_rd_valid_r;

  // TLB slots
  logic [TAG_W-1:0]     tlb_tag_r   [TLB_ENTRIES];
  logic [FRAME_W-1:0]   tlb_frame_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_r;
  logic [PTR_W-1:0]     ptr_r;

  logic                 take;
  logic                 hit_c;
  logic [FRAME_W-1:0]   hit_frame_c;
  logic                 hit_r;
  logic [FRAME_W-1:0]   hit_frame_r;
  logic [TAG_W-1:0]     tag_r;
  logic [OFFSET_W-1:0]  off_r;
  logic                 tlb_fill;
  status_t              look_status;
  logic [FRAME_W-1:0]   look_frame;

  assign take = (state_r == BK_IDLE) && cmd_valid && res_space;

  // Parallel tag compare against every slot
  always_comb begin
    hit_c       = 1'b0;
    hit_frame_c = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!hit_c && tlb_valid_r[i] && (tlb_tag_r[i] == cmd_tag)) begin
        hit_c       = 1'b1;
        hit_frame_c = tlb_frame_r[i];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (take && (cmd.kind == CMD_TRANSLATE)) begin
          state_nxt = BK_LOOK;
        end
      end
      BK_LOOK: begin
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    look_status = hit_r ? ST_HIT : (pt_rd_valid_r ? ST_MISS : ST_FAULT);
    look_frame  = hit_r ? hit_frame_r : pt_frame_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    tlb_fill    = 1'b0;
    res         = '{status: ST_WRITTEN, phys_addr: '0};
    case (state_r)
      BK_IDLE: begin
        cmd_pop = take;
        if (take && (cmd.kind != CMD_TRANSLATE)) begin
          res_push   = 1'b1;
          res.status = direct_status(cmd.kind);
        end
      end
      BK_LOOK: begin
        res_push   = 1'b1;
        res.status = look_status;
        tlb_fill   = (look_status == ST_MISS);
        if ((look_status == ST_HIT) || (look_status == ST_MISS)) begin
          res.phys_addr = ADDR_W'(look_frame) * ADDR_W'(PAGE_SIZE) + ADDR_W'(off_r);
        end
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take && (cmd.kind == CMD_WRITE)) begin
      pt_frame_mem[cmd_tag] <= cmd.frame;
    end
    if (take) begin
      pt_frame_r <= pt_frame_mem[cmd_tag];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pt_rd_valid_r <= pt_valid_r[cmd_tag];
      hit_r         <= hit_c;
      hit_frame_r   <= hit_frame_c;
      tag_r         <= cmd_tag;
      off_r         <= cmd.offset;
    end
    if (tlb_fill) begin
      tlb_tag_r[ptr_r]   <= tag_r;
      tlb_frame_r[ptr_r] <= pt_frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pt_valid_r  <= '0;
      tlb_valid_r <= '0;
      ptr_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (take && (cmd.kind == CMD_WRITE)) begin
        pt_valid_r[cmd_tag] <= cmd.valid;
      end
      if (tlb_fill) begin
        tlb_valid_r[ptr_r] <= 1'b1;
        // advance FIFO pointer, wrap at the last slot
        if (ptr_r == PTR_W'(TLB_ENTRIES - 1)) begin
          ptr_r <= '0;
        end else begin
          ptr_r <= ptr_r + PTR_W'(1);
        end
      end
    end
  end

endmodule

// File: rtl/core/tlbft_resq.sv
`timescale 1ns / 1ps
module tlbft_resq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tlbft_pkg::res_t push_res,
  output logic            space,
  output logic            empty,
  input  logic            pop,
  output tlbft_pkg::res_t head
);
  import tlbft_pkg::*;

  res_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign space   = (cnt_r != 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = q_r[rd_ptr_r];
  assign do_push = push && space;
  assign do_pop  = pop && !empty;
  assign cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/tlb_fifo_two_level_translate_core.sv
`timescale 1ns / 1ps
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------------
// in_       | in_push / in_full  | op, table_sel, page_sel, offset, entry_frame,
//           |                    | entry_valid
// out_      | out_pop / out_empty| status, phys_addr
//
// A write or a range error is answered as the back end takes it; a translation does
// the TLB compare and page-table read when taken (BK_IDLE), and forms the address and
// fills the TLB in BK_LOOK, as the back end works on one transaction at a time.
// Reset (rst_n low, synchronous) empties both queues, invalidates all page-table
// entries and TLB slots and zeroes the FIFO pointer; no clearing pass.
// Both sides have 2-entry queues; a full result queue stalls the back end and so backs up the input queue.
module tlb_fifo_two_level_translate_core #(
  parameter int TLB_ENTRIES     = 10,
  parameter int PAGE_SIZE       = 64,
  parameter int NUM_TABLES      = 4,
  parameter int PAGES_PER_TABLE = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_op,
  input  logic [tlbft_pkg::SEL_W-1:0]    in_table_sel,
  input  logic [tlbft_pkg::SEL_W-1:0]    in_page_sel,
  input  logic [tlbft_pkg::OFFSET_W-1:0] in_offset,
  input  logic [tlbft_pkg::FRAME_W-1:0]  in_entry_frame,
  input  logic                           in_entry_valid,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [2:0]                     out_status,
  output logic [tlbft_pkg::ADDR_W-1:0]   out_phys_addr
);
  import tlbft_pkg::*;

  localparam int PT_DEPTH = NUM_TABLES * PAGES_PER_TABLE;
  localparam int TAG_W    = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;

  logic             cmd_valid;
  cmd_t             cmd;
  logic [TAG_W-1:0] cmd_tag;
  logic             cmd_pop;
  logic             res_space;
  logic             res_push;
  res_t             res;
  res_t             head;

  // Front end: range checks, tag build, command queue
  tlbft_front #(
    .NUM_TABLES      (NUM_TABLES),
    .PAGES_PER_TABLE (PAGES_PER_TABLE),
    .PAGE_SIZE       (PAGE_SIZE),
    .TAG_W           (TAG_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .full        (in_full),
    .op          (in_op),
    .table_sel   (in_table_sel),
    .page_sel    (in_page_sel),
    .offset      (in_offset),
    .entry_frame (in_entry_frame),
    .entry_valid (in_entry_valid),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_tag     (cmd_tag),
    .cmd_pop     (cmd_pop)
  );

  // Back end: page-table writes, TLB lookup and FIFO fill
  tlbft_back #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_SIZE   (PAGE_SIZE),
    .PT_DEPTH    (PT_DEPTH),
    .TAG_W       (TAG_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_tag   (cmd_tag),
    .cmd_pop   (cmd_pop),
    .res_space (res_space),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue: hold finished transactions until popped
  tlbft_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_res (res),
    .space    (res_space),
    .empty    (out_empty),
    .pop      (out_pop),
    .head     (head)
  );

  assign out_status    = head.status;
  assign out_phys_addr = head.phys_addr;

endmodule

// File: rtl/core/tlbft_checker.sv
`timescale 1ns / 1ps
module tlbft_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_push,
  input logic                         in_full,
  input logic                         out_empty,
  input logic                         out_pop,
  input logic [2:0]                   out_status,
  input logic [tlbft_pkg::ADDR_W-1:0] out_phys_addr
);
  import tlbft_pkg::*;

  // Reset drains the result queue
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Reset frees the input queue
  a_rst_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full after reset");

  // Only hits and misses carry an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status != ST_HIT) && (out_status != ST_MISS))
      |-> (out_phys_addr == '0))
    else $error("address on a non-translated result");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_status) && $stable(out_phys_addr)))
    else $error("waiting result changed");

endmodule

bind tlb_fifo_two_level_translate_core tlbft_checker u_tlbft_checker (.*);
